/* src/gsal_pkg.sv */
// Shared constants, register indexes and types for the Gaussian shadow alpha lookup.
// Used by gsal_config, gsal_table_mem and gaussian_shadow_alpha_lookup; no dependencies.
package gsal_pkg;

    // Default kernel table dimension (rows and columns).
    localparam int MAX_KERNEL_DIM_DEFAULT = 65;

    // Field widths.
    localparam int TABLE_W    = 17;
    localparam int ROW_W      = 7;
    localparam int COL_W      = 7;
    localparam int PIX_W      = 12;
    localparam int ALPHA_W    = 8;
    localparam int OFS_W      = 8;
    localparam int WIN_W      = 13;
    localparam int SIDE_W     = 2;
    localparam int SIZE_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int S_TDATA_W  = 56;

    // Internal widths. The half span never exceeds 48, so kernel coordinates
    // stay within 0..96 whatever the table dimension.
    localparam int POS_W   = 16;
    localparam int HALF_W  = 6;
    localparam int COORD_W = 7;
    localparam int SD_W    = 5;
    localparam int SUM_W   = 18;
    localparam int PROD_W  = SUM_W + ALPHA_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_ALPHA = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW_SIZE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_ENABLE   = 3'd7;

    // Shadow strip sides.
    localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd3;

    // Operation codes carried in tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register reset values.
    localparam logic [ALPHA_W-1:0] ALPHA_RESET    = 8'd168;
    localparam logic [OFS_W-1:0]   OFFSET_X_RESET = 8'd0;
    localparam logic [OFS_W-1:0]   OFFSET_Y_RESET = 8'd2;
    localparam logic [WIN_W-1:0]   WINDOW_RESET   = 13'd1000;
    localparam logic [SIDE_W-1:0]  SIDE_RESET     = SIDE_TOP;
    localparam logic [SIZE_W-1:0]  SIZE_RESET     = 5'd10;

    // Output alpha limits.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 8'd1;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

    // Derived configuration handed to the pixel pipeline.
    // lbase is the left/top edge before subtracting the pixel coordinate,
    // rbase the right/bottom edge likewise.
    typedef struct packed {
        logic [ALPHA_W-1:0]      alpha;
        logic                    draw_enable;
        logic [HALF_W-1:0]       half;
        logic signed [POS_W-1:0] lbase_x;
        logic signed [POS_W-1:0] rbase_x;
        logic signed [POS_W-1:0] lbase_y;
        logic signed [POS_W-1:0] rbase_y;
    } cfg_t;

endpackage

/* src/gsal_config.sv */
// Configuration registers and the values derived from them for the pixel pipeline.
// Depends on gsal_pkg.
module gsal_config #(
    parameter int MAX_KERNEL_DIM = gsal_pkg::MAX_KERNEL_DIM_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gsal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsal_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gsal_pkg::cfg_t                   cfg
);

    // Largest kernel sigma that still fits the table.
    localparam int SdMax = (MAX_KERNEL_DIM - 1) / 8;
    localparam logic [gsal_pkg::SD_W-1:0] SD_CAP = gsal_pkg::SD_W'(SdMax);

    logic [gsal_pkg::ALPHA_W-1:0] alpha_reg;
    logic [gsal_pkg::OFS_W-1:0]   offset_x_reg;
    logic [gsal_pkg::OFS_W-1:0]   offset_y_reg;
    logic [gsal_pkg::WIN_W-1:0]   window_width_reg;
    logic [gsal_pkg::WIN_W-1:0]   window_height_reg;
    logic [gsal_pkg::SIDE_W-1:0]  side_reg;
    logic [gsal_pkg::SIZE_W-1:0]  shadow_size_reg;
    logic                         draw_enable_reg;

    gsal_pkg::cfg_t cfg_reg;
    gsal_pkg::cfg_t cfg_next;

    logic [8:0]                      size_mul;
    logic [gsal_pkg::SD_W-1:0]       sd_raw;
    logic [gsal_pkg::SD_W-1:0]       sd;
    logic signed [gsal_pkg::POS_W-1:0] win_x;
    logic signed [gsal_pkg::POS_W-1:0] win_y;
    logic signed [gsal_pkg::POS_W-1:0] ofs_x;
    logic signed [gsal_pkg::POS_W-1:0] ofs_y;
    logic signed [gsal_pkg::POS_W-1:0] width_s;
    logic signed [gsal_pkg::POS_W-1:0] height_s;
    logic signed [gsal_pkg::POS_W-1:0] size_s;

    assign cfg_ready = 1'b1;

    // Register writes; the user must write only while the pipeline is idle, unchecked here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg         <= gsal_pkg::ALPHA_RESET;
            offset_x_reg      <= gsal_pkg::OFFSET_X_RESET;
            offset_y_reg      <= gsal_pkg::OFFSET_Y_RESET;
            window_width_reg  <= gsal_pkg::WINDOW_RESET;
            window_height_reg <= gsal_pkg::WINDOW_RESET;
            side_reg          <= gsal_pkg::SIDE_RESET;
            shadow_size_reg   <= gsal_pkg::SIZE_RESET;
            draw_enable_reg   <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gsal_pkg::REG_CURRENT_ALPHA: alpha_reg         <= cfg_data[7:0];
                gsal_pkg::REG_OFFSET_X:      offset_x_reg      <= cfg_data[7:0];
                gsal_pkg::REG_OFFSET_Y:      offset_y_reg      <= cfg_data[7:0];
                gsal_pkg::REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data;
                gsal_pkg::REG_WINDOW_HEIGHT: window_height_reg <= cfg_data;
                gsal_pkg::REG_SIDE:          side_reg          <= cfg_data[1:0];
                gsal_pkg::REG_SHADOW_SIZE:   shadow_size_reg   <= cfg_data[4:0];
                gsal_pkg::REG_DRAW_ENABLE:   draw_enable_reg   <= cfg_data[0];
                default:                     draw_enable_reg   <= draw_enable_reg;
            endcase
        end
    end

    // Kernel half span: sigma = floor(2*size/5) as (size*13)>>5, exact for 5-bit sizes.
    always_comb
    begin
        size_mul = 9'(shadow_size_reg) * 9'd13;
        sd_raw   = gsal_pkg::SD_W'(size_mul[8:5]);
        sd       = (sd_raw > SD_CAP) ? SD_CAP : sd_raw;
    end

    // Window offset per strip side, then the edge bases of the rectangle.
    always_comb
    begin
        width_s  = signed'(gsal_pkg::POS_W'(window_width_reg));
        height_s = signed'(gsal_pkg::POS_W'(window_height_reg));
        size_s   = signed'(gsal_pkg::POS_W'(shadow_size_reg));
        ofs_x    = signed'({{(gsal_pkg::POS_W-gsal_pkg::OFS_W){offset_x_reg[7]}}, offset_x_reg});
        ofs_y    = signed'({{(gsal_pkg::POS_W-gsal_pkg::OFS_W){offset_y_reg[7]}}, offset_y_reg});
        case (side_reg)
            gsal_pkg::SIDE_TOP:
            begin
                win_x = '0;
                win_y = -size_s;
            end
            gsal_pkg::SIDE_BOTTOM:
            begin
                win_x = '0;
                win_y = height_s;
            end
            gsal_pkg::SIDE_LEFT:
            begin
                win_x = -size_s;
                win_y = -size_s;
            end
            default:
            begin
                win_x = width_s;
                win_y = -size_s;
            end
        endcase

        cfg_next.alpha       = alpha_reg;
        cfg_next.draw_enable = draw_enable_reg;
        cfg_next.half        = {sd[3:0], 2'b00};
        cfg_next.lbase_x     = ofs_x - win_x;
        cfg_next.rbase_x     = ofs_x - win_x + width_s - 16'sd1;
        cfg_next.lbase_y     = ofs_y - win_y;
        cfg_next.rbase_y     = ofs_y - win_y + height_s - 16'sd1;
    end

    // Derived values are registered; they follow a register write in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/gsal_table_mem.sv */
// One copy of the prefix table: one write port, two registered read ports.
// Depends on gsal_pkg.
module gsal_table_mem #(
    parameter int DEPTH = gsal_pkg::MAX_KERNEL_DIM_DEFAULT * gsal_pkg::MAX_KERNEL_DIM_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [gsal_pkg::TABLE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr0,
    input  logic [AW-1:0]                 rd_addr1,
    output logic [gsal_pkg::TABLE_W-1:0]  rd_data0,
    output logic [gsal_pkg::TABLE_W-1:0]  rd_data1
);

    logic [gsal_pkg::TABLE_W-1:0] mem [DEPTH];
    logic [gsal_pkg::TABLE_W-1:0] rd_data0_reg;
    logic [gsal_pkg::TABLE_W-1:0] rd_data1_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read ports; data holds while the pipeline stage behind is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data0_reg <= mem[rd_addr0];
            rd_data1_reg <= mem[rd_addr1];
        end
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

/* src/gaussian_shadow_alpha_lookup.sv */
// Gaussian drop-shadow alpha lookup: top level with the pixel pipeline.
// Depends on gsal_pkg, gsal_config and gsal_table_mem.
//
// Use: software first loads the summed-area table of the Gaussian kernel, one
// entry per input beat with s_tuser = 0 (row, column, Q1.16 value). Pixel
// queries follow with s_tuser = 1 and return one 8-bit alpha beat on m_tdata;
// loads return nothing. The cfg channel writes the eight control registers by
// index and is always ready; write it only while no query is in flight.
// Throughput is one beat per cycle for loads and queries alike while m_tready
// is high: the four corner reads of a query are served by two table copies
// with two read ports each, and each load writes both copies. A query's path
// holds six registers (input register, loaded at the accepting edge, then
// clamp, table read, corner sum, scaling multiply and output register).
// A load writes the table in the same stage in which later queries read it,
// so a query always sees every earlier load. When m_tready is low the stages
// fill up behind the output register; the input keeps taking beats until all
// six are full, then s_tready drops.
// Reset empties the pipeline and restores the register defaults. The table
// is not cleared: an entry must be loaded before a query reads it.
module gaussian_shadow_alpha_lookup #(
    parameter int MAX_KERNEL_DIM = gsal_pkg::MAX_KERNEL_DIM_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input beats.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // table_row[6:0], table_col[13:7], table_value[30:14], pixel_x[42:31],
    // pixel_y[54:43], zero pad[55]
    input  logic [gsal_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[0]
    input  logic                             s_tuser,
    // Result beats.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_alpha[7:0]
    output logic [gsal_pkg::ALPHA_W-1:0]     m_tdata,
    // Configuration writes.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gsal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gsal_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int Depth = MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int AW    = $clog2(Depth);

    // Field positions in s_tdata.
    localparam int RowLsb   = 0;
    localparam int ColLsb   = RowLsb + gsal_pkg::ROW_W;
    localparam int ValueLsb = ColLsb + gsal_pkg::COL_W;
    localparam int PxLsb    = ValueLsb + gsal_pkg::TABLE_W;
    localparam int PyLsb    = PxLsb + gsal_pkg::PIX_W;

    // Linear table address of a row and column.
    function automatic logic [AW-1:0] table_addr(input logic [gsal_pkg::COORD_W-1:0] row,
                                                 input logic [gsal_pkg::COORD_W-1:0] col);
        table_addr = AW'(int'(row) * MAX_KERNEL_DIM + int'(col));
    endfunction

    // Clamp an edge to [-half, half] and shift it to a table coordinate.
    function automatic logic [gsal_pkg::COORD_W-1:0] clamp_coord(
        input logic signed [gsal_pkg::POS_W-1:0] v,
        input logic [gsal_pkg::HALF_W-1:0]       half
    );
        logic signed [gsal_pkg::POS_W-1:0] h;
        logic signed [gsal_pkg::POS_W-1:0] shifted;
        h       = signed'(gsal_pkg::POS_W'(half));
        shifted = v + h;
        if (v < -h)
            clamp_coord = '0;
        else if (v > h)
            clamp_coord = gsal_pkg::COORD_W'({half, 1'b0});
        else
            clamp_coord = gsal_pkg::COORD_W'(shifted);
    endfunction

    gsal_pkg::cfg_t cfg;

    // Stage advance enables, from the output back to the input.
    logic take1;
    logic take2;
    logic take3;
    logic take4;
    logic take5;
    logic take_out;

    // Stage 1: input register.
    logic                           st1_valid_reg;
    logic                           st1_op_reg;
    logic [gsal_pkg::ROW_W-1:0]     st1_row_reg;
    logic [gsal_pkg::COL_W-1:0]     st1_col_reg;
    logic [gsal_pkg::TABLE_W-1:0]   st1_value_reg;
    logic [gsal_pkg::PIX_W-1:0]     st1_px_reg;
    logic [gsal_pkg::PIX_W-1:0]     st1_py_reg;

    // Stage 2: clamped rectangle and load address.
    logic                           st2_valid_reg;
    logic                           st2_op_reg;
    logic                           st2_in_range_reg;
    logic [AW-1:0]                  st2_waddr_reg;
    logic [gsal_pkg::TABLE_W-1:0]   st2_value_reg;
    logic [gsal_pkg::COORD_W-1:0]   st2_lx_reg;
    logic [gsal_pkg::COORD_W-1:0]   st2_ex_reg;
    logic [gsal_pkg::COORD_W-1:0]   st2_ty_reg;
    logic [gsal_pkg::COORD_W-1:0]   st2_ey_reg;

    // Stage 3: table read data (in the memories) and corner flags.
    logic                           st3_valid_reg;
    logic                           st3_sx_ok_reg;
    logic                           st3_sy_ok_reg;

    // Stage 4: range sum; stage 5: scaled product; then the output register.
    logic                           st4_valid_reg;
    logic [gsal_pkg::SUM_W-1:0]     st4_sum_reg;
    logic                           st5_valid_reg;
    logic [gsal_pkg::PROD_W-1:0]    st5_prod_reg;
    logic                           out_valid_reg;
    logic [gsal_pkg::ALPHA_W-1:0]   out_alpha_reg;

    // Combinational stage results.
    logic [AW-1:0]                  waddr_next;
    logic                           in_range_next;
    logic signed [gsal_pkg::POS_W-1:0] px_s;
    logic signed [gsal_pkg::POS_W-1:0] py_s;
    logic [gsal_pkg::COORD_W-1:0]   sx;
    logic [gsal_pkg::COORD_W-1:0]   sy;
    logic                           mem_wr_en;
    logic [AW-1:0]                  addr_ey_ex;
    logic [AW-1:0]                  addr_sy_ex;
    logic [AW-1:0]                  addr_ey_sx;
    logic [AW-1:0]                  addr_sy_sx;
    logic [gsal_pkg::TABLE_W-1:0]   rd_ey_ex;
    logic [gsal_pkg::TABLE_W-1:0]   rd_sy_ex;
    logic [gsal_pkg::TABLE_W-1:0]   rd_ey_sx;
    logic [gsal_pkg::TABLE_W-1:0]   rd_sy_sx;
    logic signed [gsal_pkg::SUM_W+1:0] term_a0;
    logic signed [gsal_pkg::SUM_W+1:0] term_a1;
    logic signed [gsal_pkg::SUM_W+1:0] term_b0;
    logic signed [gsal_pkg::SUM_W+1:0] term_b1;
    logic signed [gsal_pkg::SUM_W+1:0] sum_full;
    logic [gsal_pkg::SUM_W-1:0]     sum_next;
    logic [gsal_pkg::PROD_W-1:0]    prod_next;
    logic [gsal_pkg::PROD_W-17:0]   scaled;
    logic [gsal_pkg::ALPHA_W-1:0]   alpha_next;

    gsal_config #(
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
    ) u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A stage takes new data when it is empty or its successor takes it.
    assign take_out = !out_valid_reg || m_tready;
    assign take5    = !st5_valid_reg || take_out;
    assign take4    = !st4_valid_reg || take5;
    assign take3    = !st3_valid_reg || take4;
    assign take2    = !st2_valid_reg || take3;
    assign take1    = !st1_valid_reg || take2;
    assign s_tready = take1;

    // Valid bits; loads leave the pipeline after the table write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                st1_valid_reg <= s_tvalid;
            if (take2)
                st2_valid_reg <= st1_valid_reg;
            if (take3)
                st3_valid_reg <= st2_valid_reg && (st2_op_reg == gsal_pkg::OP_QUERY);
            if (take4)
                st4_valid_reg <= st3_valid_reg;
            if (take5)
                st5_valid_reg <= st4_valid_reg;
            if (take_out)
                out_valid_reg <= st5_valid_reg;
        end
    end

    // Stage 1 capture.
    always_ff @(posedge clk)
    begin
        if (take1)
        begin
            st1_op_reg    <= s_tuser;
            st1_row_reg   <= s_tdata[RowLsb +: gsal_pkg::ROW_W];
            st1_col_reg   <= s_tdata[ColLsb +: gsal_pkg::COL_W];
            st1_value_reg <= s_tdata[ValueLsb +: gsal_pkg::TABLE_W];
            st1_px_reg    <= s_tdata[PxLsb +: gsal_pkg::PIX_W];
            st1_py_reg    <= s_tdata[PyLsb +: gsal_pkg::PIX_W];
        end
    end

    // Stage 1 logic: load address and the clamped window rectangle.
    always_comb
    begin
        waddr_next    = table_addr(st1_row_reg, st1_col_reg);
        in_range_next = (int'(st1_row_reg) < MAX_KERNEL_DIM) &&
                        (int'(st1_col_reg) < MAX_KERNEL_DIM);
        px_s          = signed'(gsal_pkg::POS_W'(st1_px_reg));
        py_s          = signed'(gsal_pkg::POS_W'(st1_py_reg));
    end

    always_ff @(posedge clk)
    begin
        if (take2)
        begin
            st2_op_reg       <= st1_op_reg;
            st2_in_range_reg <= in_range_next;
            st2_waddr_reg    <= waddr_next;
            st2_value_reg    <= st1_value_reg;
            st2_lx_reg       <= clamp_coord(cfg.lbase_x - px_s, cfg.half);
            st2_ex_reg       <= clamp_coord(cfg.rbase_x - px_s, cfg.half);
            st2_ty_reg       <= clamp_coord(cfg.lbase_y - py_s, cfg.half);
            st2_ey_reg       <= clamp_coord(cfg.rbase_y - py_s, cfg.half);
        end
    end

    // Stage 2 logic: corner addresses and the table write of a load.
    always_comb
    begin
        sx         = (st2_lx_reg == '0) ? '0 : st2_lx_reg - 1'b1;
        sy         = (st2_ty_reg == '0) ? '0 : st2_ty_reg - 1'b1;
        addr_ey_ex = table_addr(st2_ey_reg, st2_ex_reg);
        addr_sy_ex = table_addr(sy, st2_ex_reg);
        addr_ey_sx = table_addr(st2_ey_reg, sx);
        addr_sy_sx = table_addr(sy, sx);
        mem_wr_en  = st2_valid_reg && (st2_op_reg == gsal_pkg::OP_LOAD) &&
                     st2_in_range_reg && take3;
    end

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            st3_sx_ok_reg <= (st2_lx_reg != '0);
            st3_sy_ok_reg <= (st2_ty_reg != '0);
        end
    end

    // Copy A serves the end column, copy B the start column.
    gsal_table_mem #(
        .DEPTH (Depth),
        .AW    (AW)
    ) u_mem_a (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (st2_waddr_reg),
        .wr_data  (st2_value_reg),
        .rd_en    (take3),
        .rd_addr0 (addr_ey_ex),
        .rd_addr1 (addr_sy_ex),
        .rd_data0 (rd_ey_ex),
        .rd_data1 (rd_sy_ex)
    );

    gsal_table_mem #(
        .DEPTH (Depth),
        .AW    (AW)
    ) u_mem_b (
        .clk      (clk),
        .wr_en    (mem_wr_en),
        .wr_addr  (st2_waddr_reg),
        .wr_data  (st2_value_reg),
        .rd_en    (take3),
        .rd_addr0 (addr_ey_sx),
        .rd_addr1 (addr_sy_sx),
        .rd_data0 (rd_ey_sx),
        .rd_data1 (rd_sy_sx)
    );

    // Stage 3 logic: four-corner range sum, negative sums taken as zero.
    always_comb
    begin
        term_a0  = signed'({3'b000, rd_ey_ex});
        term_a1  = st3_sy_ok_reg ? signed'({3'b000, rd_sy_ex}) : '0;
        term_b0  = st3_sx_ok_reg ? signed'({3'b000, rd_ey_sx}) : '0;
        term_b1  = (st3_sy_ok_reg && st3_sx_ok_reg) ? signed'({3'b000, rd_sy_sx}) : '0;
        sum_full = term_a0 - term_a1 - term_b0 + term_b1;
        sum_next = sum_full[gsal_pkg::SUM_W+1] ? '0 : sum_full[gsal_pkg::SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (take4)
        begin
            st4_sum_reg <= sum_next;
        end
    end

    // Stage 4 logic: scale by the peak opacity.
    assign prod_next = gsal_pkg::PROD_W'(st4_sum_reg) * gsal_pkg::PROD_W'(cfg.alpha);

    always_ff @(posedge clk)
    begin
        if (take5)
        begin
            st5_prod_reg <= prod_next;
        end
    end

    // Stage 5 logic: drop the Q0.16 fraction, saturate, floor at one.
    always_comb
    begin
        scaled = st5_prod_reg[gsal_pkg::PROD_W-1:16];
        if (!cfg.draw_enable)
            alpha_next = gsal_pkg::ALPHA_ONE;
        else if (scaled > 10'(gsal_pkg::ALPHA_MAX))
            alpha_next = gsal_pkg::ALPHA_MAX;
        else if (scaled == '0)
            alpha_next = gsal_pkg::ALPHA_ONE;
        else
            alpha_next = scaled[gsal_pkg::ALPHA_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            out_alpha_reg <= alpha_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_alpha_reg;

    // A delivered alpha is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_alpha_reg != '0))
        else $error("zero alpha presented on the output");

    // A load leaves the pipeline after its table write and makes no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st2_valid_reg && (st2_op_reg == gsal_pkg::OP_LOAD) && take3) |=> !st3_valid_reg)
        else $error("load beat reached the read data stage");

    // A disabled shadow gives an alpha of one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st5_valid_reg && take_out && !cfg.draw_enable) |=>
            (out_alpha_reg == gsal_pkg::ALPHA_ONE))
        else $error("disabled shadow did not give alpha one");

    // A stalled input stage keeps its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (st1_valid_reg && !take2) |=> (st1_valid_reg && $stable(st1_px_reg)))
        else $error("stalled input stage lost its item");

endmodule

/* tb/gaussian_shadow_alpha_lookup_test.sv */
// Self-checking testbench for the Gaussian shadow alpha lookup block.
// Loads the summed-area table, sweeps registers and pixel queries, and checks
// every alpha beat against an in-bench predictor. Depends on gsal_pkg.
module gaussian_shadow_alpha_lookup_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gsal_pkg::*;

    localparam int KDIM           = MAX_KERNEL_DIM_DEFAULT;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 90;
    localparam int RANDOM_PHASES  = 10;

    // One input beat before packing.
    typedef struct packed {
        logic               op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [TABLE_W-1:0] value;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
    } beat_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [ALPHA_W-1:0]    m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the kernel table and of the control registers.
    logic [TABLE_W-1:0]       kernel_prefix [0:KDIM-1][0:KDIM-1];
    logic [ALPHA_W-1:0]       cur_alpha   = ALPHA_RESET;
    logic signed [OFS_W-1:0]  ofs_x       = OFFSET_X_RESET;
    logic signed [OFS_W-1:0]  ofs_y       = OFFSET_Y_RESET;
    logic [WIN_W-1:0]         win_w       = WINDOW_RESET;
    logic [WIN_W-1:0]         win_h       = WINDOW_RESET;
    logic [SIDE_W-1:0]        strip_side  = SIDE_RESET;
    logic [SIZE_W-1:0]        shadow_size = SIZE_RESET;
    logic                     draw_on     = 1'b1;

    // Table entries already queued for loading; queries read only these.
    bit                 loaded [0:KDIM-1][0:KDIM-1];

    beat_t              pending_beats [$];
    logic [ALPHA_W-1:0] expected_alpha [$];
    beat_t              cur_beat;
    int                 burst_left = 0;
    int                 gap_left   = 0;
    int                 stall_period = 1;
    int                 stall_len    = 0;
    int                 pattern_pos  = 0;
    int                 pattern_age  = 0;
    int                 idle_cycles  = 0;
    int                 mismatches   = 0;

    gaussian_shadow_alpha_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clip_span(int v, int lim);
        if (v < -lim)
            return -lim;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // Table corners of the clamped window rectangle of one pixel under the
    // current registers; a start corner below zero is not read.
    function automatic void window_corners(input int px, input int py,
                                           output int sx, output int ex,
                                           output int sy, output int ey);
        int sd, half, wx, wy, x, y;
        sd = (2 * int'(shadow_size)) / 5;
        if (sd > (KDIM - 1) / 8)
            sd = (KDIM - 1) / 8;
        half = 4 * sd;
        wx = 0;
        wy = -int'(shadow_size);
        case (strip_side)
            SIDE_BOTTOM: wy = int'(win_h);
            SIDE_LEFT:   wx = -int'(shadow_size);
            SIDE_RIGHT:  wx = int'(win_w);
            default:     ;
        endcase
        x = px + wx - int'(ofs_x);
        y = py + wy - int'(ofs_y);
        sx = clip_span(-x, half) + half - 1;
        ex = clip_span(-x + int'(win_w) - 1, half) + half;
        sy = clip_span(-y, half) + half - 1;
        ey = clip_span(-y + int'(win_h) - 1, half) + half;
    endfunction

    // Alpha of one pixel: four-corner sum of the clamped window rectangle,
    // scaled by the peak opacity, capped at 255 and floored at one.
    function automatic logic [ALPHA_W-1:0] shadow_alpha(logic [PIX_W-1:0] px,
                                                        logic [PIX_W-1:0] py);
        int     sx, ex, sy, ey;
        longint s, v;
        if (!draw_on)
            return ALPHA_ONE;
        window_corners(int'(px), int'(py), sx, ex, sy, ey);
        s = longint'(kernel_prefix[ey][ex]);
        if (sy >= 0)
            s -= longint'(kernel_prefix[sy][ex]);
        if (sx >= 0)
            s -= longint'(kernel_prefix[ey][sx]);
        if (sy >= 0 && sx >= 0)
            s += longint'(kernel_prefix[sy][sx]);
        // A negative range sum counts as empty.
        if (s < 0)
            s = 0;
        v = (s * longint'(cur_alpha)) >>> 16;
        if (v > 255)
            v = 255;
        if (v < 1)
            v = 1;
        return v[ALPHA_W-1:0];
    endfunction

    // Effect of one accepted beat: a load updates the table, a query
    // queues its alpha.
    function automatic void apply_beat(beat_t b);
        if (b.op == OP_LOAD)
        begin
            if (int'(b.row) < KDIM && int'(b.col) < KDIM)
                kernel_prefix[b.row][b.col] = b.value;
        end
        else
            expected_alpha.push_back(shadow_alpha(b.px, b.py));
    endfunction

    // Separable linear ramp that rises to one at the far corner.
    function automatic int ramp_prefix(int row, int col);
        if (row > KDIM - 1)
            row = KDIM - 1;
        if (col > KDIM - 1)
            col = KDIM - 1;
        return ((row + 1) * (col + 1) * 65536) / (KDIM * KDIM);
    endfunction

    function automatic void queue_load(int row, int col, int value);
        beat_t b;
        b       = '0;
        b.op    = OP_LOAD;
        b.row   = row[ROW_W-1:0];
        b.col   = col[COL_W-1:0];
        b.value = value[TABLE_W-1:0];
        if (row >= 0 && row < KDIM && col >= 0 && col < KDIM)
            loaded[row][col] = 1'b1;
        pending_beats.push_back(b);
    endfunction

    // Loads a ramp value into an entry that has not been written yet.
    function automatic void cover_entry(int row, int col);
        if (!loaded[row][col])
            queue_load(row, col, ramp_prefix(row, col));
    endfunction

    // A query is preceded by loads of any corner entry it reads that is
    // still unwritten.
    function automatic void queue_query(int px, int py);
        beat_t b;
        int    sx, ex, sy, ey;
        window_corners(px, py, sx, ex, sy, ey);
        cover_entry(ey, ex);
        if (sy >= 0)
            cover_entry(sy, ex);
        if (sx >= 0)
            cover_entry(ey, sx);
        if (sy >= 0 && sx >= 0)
            cover_entry(sy, sx);
        b    = '0;
        b.op = OP_QUERY;
        b.px = px[PIX_W-1:0];
        b.py = py[PIX_W-1:0];
        pending_beats.push_back(b);
    endfunction

    // Random value in [lo, hi] that lands on either end fairly often.
    function automatic int pick_edge(int lo, int hi);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 3)
            return lo;
        if (roll < 6)
            return hi;
        return lo + int'($urandom_range(hi - lo, 0));
    endfunction

    // Pixel coordinate: mostly near the strip origin or near the far window
    // edge, where the rectangle crosses the kernel span.
    function automatic int pick_coord(int dim);
        int roll, v;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return $urandom_range(0, 100);
        if (roll < 7)
        begin
            v = dim + int'($urandom_range(0, 120)) - 60;
            return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
        end
        return $urandom_range(0, 4095);
    endfunction

    // One register write beat; the predictor copy follows on acceptance.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CURRENT_ALPHA: cur_alpha   = val[ALPHA_W-1:0];
            REG_OFFSET_X:      ofs_x       = val[OFS_W-1:0];
            REG_OFFSET_Y:      ofs_y       = val[OFS_W-1:0];
            REG_WINDOW_WIDTH:  win_w       = val[WIN_W-1:0];
            REG_WINDOW_HEIGHT: win_h       = val[WIN_W-1:0];
            REG_SIDE:          strip_side  = val[SIDE_W-1:0];
            REG_SHADOW_SIZE:   shadow_size = val[SIZE_W-1:0];
            REG_DRAW_ENABLE:   draw_on     = val[0];
            default:           ;
        endcase
    endtask

    // Waits until every beat is sent and every alpha has come back, then lets
    // trailing loads drain through the pipeline.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || s_tvalid || expected_alpha.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Input driver: bursts of beats separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_beat(cur_beat);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    cur_beat = pending_beats.pop_front();
                    s_tdata  <= {1'b0, cur_beat.py, cur_beat.px, cur_beat.value,
                                 cur_beat.col, cur_beat.row};
                    s_tuser  <= cur_beat.op;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: a random periodic stall pattern, redrawn repeatedly.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                stall_period = $urandom_range(2, 8);
                stall_len    = ($urandom_range(0, 2) == 0) ? 0
                                                           : $urandom_range(1, stall_period - 1);
                pattern_pos  = 0;
            end
            pattern_age = (pattern_age + 1) % 200;
            m_tready <= (pattern_pos >= stall_len);
            pattern_pos = (pattern_pos + 1 >= stall_period) ? 0 : pattern_pos + 1;
        end
    end

    // Result checker against the oldest expected alpha.
    always @(posedge clk)
    begin
        logic [ALPHA_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_alpha.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pixel_alpha=%0d", m_tdata);
            end
            else
            begin
                want = expected_alpha.pop_front();
                if (m_tdata !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel_alpha mismatch: expected %0d, got %0d", want, m_tdata);
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("gaussian_shadow_alpha_lookup_test: errors");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int row, col, value;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: pixel corners, ignored loads outside the table,
        // a full-scale entry and a zeroed corner that drives the sum negative.
        queue_query(0, 0);
        queue_query(4095, 4095);
        queue_query(0, 4095);
        queue_query(4095, 0);
        queue_load(127, 0, 65536);
        queue_load(0, 127, 0);
        queue_load(64, 64, 65536);
        queue_load(32, 32, 0);
        queue_query(0, 0);
        queue_query(500, 12);
        wait_idle();

        // Left strip, empty window, oversized kernel, extreme offsets.
        set_reg(REG_SIDE, SIDE_LEFT);
        set_reg(REG_WINDOW_WIDTH, 0);
        set_reg(REG_WINDOW_HEIGHT, 1);
        set_reg(REG_SHADOW_SIZE, 31);
        set_reg(REG_CURRENT_ALPHA, 255);
        set_reg(REG_OFFSET_X, -128);
        set_reg(REG_OFFSET_Y, 127);
        queue_query(0, 0);
        queue_query(4095, 4095);
        queue_query(40, 3);
        wait_idle();

        // Right strip, largest window, zero kernel span.
        set_reg(REG_SIDE, SIDE_RIGHT);
        set_reg(REG_WINDOW_WIDTH, 8191);
        set_reg(REG_WINDOW_HEIGHT, 8191);
        set_reg(REG_SHADOW_SIZE, 0);
        set_reg(REG_OFFSET_X, 64);
        set_reg(REG_OFFSET_Y, -64);
        queue_query(0, 0);
        queue_query(4095, 0);
        wait_idle();

        // Bottom strip with the shadow switched off.
        set_reg(REG_SIDE, SIDE_BOTTOM);
        set_reg(REG_DRAW_ENABLE, 0);
        set_reg(REG_CURRENT_ALPHA, 0);
        queue_query(5, 5);
        queue_query(0, 4095);
        wait_idle();

        // Top strip, small window, largest nominal size.
        set_reg(REG_DRAW_ENABLE, 1);
        set_reg(REG_SIDE, SIDE_TOP);
        set_reg(REG_SHADOW_SIZE, 20);
        set_reg(REG_WINDOW_WIDTH, 16);
        set_reg(REG_WINDOW_HEIGHT, 16);
        set_reg(REG_CURRENT_ALPHA, 255);
        set_reg(REG_OFFSET_X, 0);
        set_reg(REG_OFFSET_Y, 0);
        queue_query(0, 0);
        queue_query(8, 20);
        queue_query(30, 10);
        wait_idle();

        // Random phases: fresh settings, then mostly queries with some reloads.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_reg(REG_CURRENT_ALPHA, pick_edge(0, 255));
            set_reg(REG_OFFSET_X, ($urandom_range(0, 9) == 0) ? pick_edge(-128, 127)
                                                              : pick_edge(-64, 64));
            set_reg(REG_OFFSET_Y, ($urandom_range(0, 9) == 0) ? pick_edge(-128, 127)
                                                              : pick_edge(-64, 64));
            set_reg(REG_WINDOW_WIDTH, ($urandom_range(0, 3) == 0) ? pick_edge(0, 8191)
                                                                  : $urandom_range(1, 200));
            set_reg(REG_WINDOW_HEIGHT, ($urandom_range(0, 3) == 0) ? pick_edge(0, 8191)
                                                                   : $urandom_range(1, 200));
            set_reg(REG_SIDE, $urandom_range(0, 3));
            set_reg(REG_SHADOW_SIZE, ($urandom_range(0, 7) == 0) ? pick_edge(0, 31)
                                                                 : pick_edge(1, 20));
            set_reg(REG_DRAW_ENABLE, ($urandom_range(0, 9) != 0));
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, KDIM - 1);
                    col = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(0, KDIM - 1);
                    if ($urandom_range(0, 1) == 0)
                        value = ramp_prefix(row, col);
                    else
                        value = ($urandom_range(0, 19) == 0) ? 65536 : $urandom_range(0, 65536);
                    queue_load(row, col, value);
                end
                else
                    queue_query(pick_coord(int'(win_w)), pick_coord(int'(win_h)));
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("gaussian_shadow_alpha_lookup_test: clean");
        else
            $display("gaussian_shadow_alpha_lookup_test: errors");
        $finish;
    end

endmodule
